// ----- hdl/rsnh_pkg.sv -----
`default_nettype none
package rsnh_pkg;

    localparam int COORD_W     = 32;
    localparam int DIR_W       = 16;
    localparam int DIST_W      = 31;
    localparam int IDX_W       = 6;
    localparam int MAX_SPHERES = 64;
    localparam int IDX_LIMIT   = (MAX_SPHERES - 1 < 63) ? MAX_SPHERES - 1 : 63;
    localparam int DIR_FRAC    = 14;

    localparam int OC_W   = COORD_W + 1;
    localparam int MUL_W  = OC_W + 1;
    localparam int PROD_W = 2 * MUL_W;
    localparam int HACC_W = OC_W + DIR_W + 2;
    localparam int H_W    = HACC_W - DIR_FRAC;
    localparam int HMAG_W = H_W - 1;
    localparam int HALF_W = HMAG_W / 2;
    localparam int DISC_W = 2 * HMAG_W;
    localparam int ROOT_W = HMAG_W;
    localparam int REM_W  = ROOT_W + 3;
    localparam int T_W    = H_W + 1;

    localparam int CALC_LAST  = 12;
    localparam int SQRT_STEPS = ROOT_W;

    localparam logic [DIST_W-1:0] MAX_DIST_RESET = DIST_W'(10000 << 12);

    typedef enum logic [3:0] {
        MS_NONE,
        MS_HX, MS_HY, MS_HZ,
        MS_OX, MS_OY, MS_OZ,
        MS_RR,
        MS_HHH, MS_HHL, MS_HLL
    } mul_sel_t;

    typedef struct packed {
        logic     load;
        mul_sel_t mul_sel;
        logic     h_latch;
        logic     sqrt_init;
        logic     sqrt_step;
        logic     decide;
        logic     emit;
    } dp_cmd_t;

    typedef struct packed {
        logic last;
    } dp_stat_t;

endpackage
`default_nettype wire

// ----- hdl/rsnh_ctrl.sv -----
`default_nettype none
module rsnh_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    output logic                   m_valid,
    input  wire logic              m_ready,
    input  wire rsnh_pkg::dp_stat_t stat,
    output rsnh_pkg::dp_cmd_t      cmd
);
    import rsnh_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_CALC, S_SQRT, S_DECIDE} state_t;

    state_t     state_reg, state_next;
    logic [3:0] step_reg, step_next;
    logic [5:0] sq_reg, sq_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_blocked;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign out_blocked = stat.last && m_valid_reg && !m_ready;

    always_comb begin
        cmd          = '0;
        cmd.mul_sel  = MS_NONE;
        state_next   = state_reg;
        step_next    = step_reg;
        sq_next      = sq_reg;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    step_next  = '0;
                    state_next = S_CALC;
                end
            end
            S_CALC: begin
                // dot products, squares, then |h|^2 in three partial products
                unique case (step_reg)
                    4'd0:  cmd.mul_sel = MS_HX;
                    4'd1:  cmd.mul_sel = MS_HY;
                    4'd2:  cmd.mul_sel = MS_HZ;
                    4'd3:  cmd.mul_sel = MS_OX;
                    4'd4:  cmd.mul_sel = MS_OY;
                    4'd5:  cmd.mul_sel = MS_OZ;
                    4'd6:  cmd.mul_sel = MS_RR;
                    4'd7:  cmd.h_latch = 1'b1;
                    4'd8:  cmd.mul_sel = MS_HHH;
                    4'd9:  cmd.mul_sel = MS_HHL;
                    4'd10: cmd.mul_sel = MS_HLL;
                    4'd12: cmd.sqrt_init = 1'b1;
                    default: cmd.mul_sel = MS_NONE;
                endcase
                if (step_reg == 4'(CALC_LAST)) begin
                    sq_next    = '0;
                    state_next = S_SQRT;
                end else begin
                    step_next = step_reg + 4'd1;
                end
            end
            S_SQRT: begin
                cmd.sqrt_step = 1'b1;
                if (sq_reg == 6'(SQRT_STEPS - 1)) begin
                    state_next = S_DECIDE;
                end else begin
                    sq_next = sq_reg + 6'd1;
                end
            end
            S_DECIDE: begin
                if (!out_blocked) begin
                    cmd.decide = 1'b1;
                    cmd.emit   = stat.last;
                    if (stat.last) begin
                        m_valid_next = 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            step_reg    <= '0;
            sq_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            sq_reg      <= sq_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/rsnh_dp.sv -----
`default_nettype none
module rsnh_dp (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire rsnh_pkg::dp_cmd_t                   cmd,
    output rsnh_pkg::dp_stat_t                       stat,
    input  wire logic                                cfg_we,
    input  wire logic [rsnh_pkg::DIST_W-1:0]         cfg_data,
    input  wire logic signed [rsnh_pkg::COORD_W-1:0] org_x,
    input  wire logic signed [rsnh_pkg::COORD_W-1:0] org_y,
    input  wire logic signed [rsnh_pkg::COORD_W-1:0] org_z,
    input  wire logic signed [rsnh_pkg::DIR_W-1:0]   dir_x,
    input  wire logic signed [rsnh_pkg::DIR_W-1:0]   dir_y,
    input  wire logic signed [rsnh_pkg::DIR_W-1:0]   dir_z,
    input  wire logic signed [rsnh_pkg::COORD_W-1:0] cen_x,
    input  wire logic signed [rsnh_pkg::COORD_W-1:0] cen_y,
    input  wire logic signed [rsnh_pkg::COORD_W-1:0] cen_z,
    input  wire logic [rsnh_pkg::DIST_W-1:0]         radius,
    input  wire logic                                last,
    output logic                                     hit_found,
    output logic [rsnh_pkg::DIST_W-1:0]              nearest_distance,
    output logic [rsnh_pkg::IDX_W-1:0]               nearest_index
);
    import rsnh_pkg::*;

    logic [DIST_W-1:0]        max_dist_reg;
    logic signed [OC_W-1:0]   ocx_reg, ocy_reg, ocz_reg;
    logic signed [DIR_W-1:0]  dx_reg, dy_reg, dz_reg;
    logic [DIST_W-1:0]        rad_in_reg;
    logic                     last_reg;

    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] prod_reg;
    mul_sel_t                 acc_sel_reg;
    logic signed [DISC_W-1:0] prod_ext;

    logic signed [HACC_W-1:0] hacc_reg;
    logic signed [DISC_W-1:0] disc_reg;
    logic signed [H_W-1:0]    h_reg;
    logic [HMAG_W-1:0]        hmag_reg;
    logic signed [H_W-1:0]    h_val;

    logic [DISC_W-1:0]        sh_reg;
    logic [REM_W-1:0]         rem_reg;
    logic [ROOT_W-1:0]        root_reg;
    logic                     miss_reg;
    logic [REM_W-1:0]         rem_sh, trial;

    logic signed [T_W-1:0]    t_val;
    logic [T_W-2:0]           t_mag;
    logic                     take;
    logic [DIST_W-1:0]        best_dist_reg, best_dist_nx;
    logic [IDX_W-1:0]         best_idx_reg, best_idx_nx;
    logic                     best_valid_reg, best_valid_nx;
    logic [IDX_W-1:0]         cnt_reg;

    logic                     hit_reg;
    logic [DIST_W-1:0]        dist_out_reg;
    logic [IDX_W-1:0]         idx_out_reg;

    assign stat.last        = last_reg;
    assign hit_found        = hit_reg;
    assign nearest_distance = dist_out_reg;
    assign nearest_index    = idx_out_reg;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.mul_sel)
            MS_HX:  begin mul_a = MUL_W'(ocx_reg); mul_b = MUL_W'(dx_reg); end
            MS_HY:  begin mul_a = MUL_W'(ocy_reg); mul_b = MUL_W'(dy_reg); end
            MS_HZ:  begin mul_a = MUL_W'(ocz_reg); mul_b = MUL_W'(dz_reg); end
            MS_OX:  begin mul_a = MUL_W'(ocx_reg); mul_b = MUL_W'(ocx_reg); end
            MS_OY:  begin mul_a = MUL_W'(ocy_reg); mul_b = MUL_W'(ocy_reg); end
            MS_OZ:  begin mul_a = MUL_W'(ocz_reg); mul_b = MUL_W'(ocz_reg); end
            MS_RR:  begin
                mul_a = $signed({{(MUL_W-DIST_W){1'b0}}, rad_in_reg});
                mul_b = $signed({{(MUL_W-DIST_W){1'b0}}, rad_in_reg});
            end
            MS_HHH: begin
                mul_a = $signed({{(MUL_W-HALF_W){1'b0}}, hmag_reg[HMAG_W-1:HALF_W]});
                mul_b = $signed({{(MUL_W-HALF_W){1'b0}}, hmag_reg[HMAG_W-1:HALF_W]});
            end
            MS_HHL: begin
                mul_a = $signed({{(MUL_W-HALF_W){1'b0}}, hmag_reg[HMAG_W-1:HALF_W]});
                mul_b = $signed({{(MUL_W-HALF_W){1'b0}}, hmag_reg[HALF_W-1:0]});
            end
            MS_HLL: begin
                mul_a = $signed({{(MUL_W-HALF_W){1'b0}}, hmag_reg[HALF_W-1:0]});
                mul_b = $signed({{(MUL_W-HALF_W){1'b0}}, hmag_reg[HALF_W-1:0]});
            end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    assign prod_ext = DISC_W'(prod_reg);
    assign h_val    = hacc_reg[HACC_W-1:DIR_FRAC];

    // one bit of the integer square root, from the next two radicand bits
    assign rem_sh = {rem_reg[REM_W-3:0], sh_reg[DISC_W-1:DISC_W-2]};
    assign trial  = {1'b0, root_reg, 2'b01};

    // near root and keep rule
    always_comb begin
        t_val = -T_W'(h_reg) - $signed({1'b0, root_reg});
        t_mag = t_val[T_W-2:0];
        take  = !miss_reg && !t_val[T_W-1] && (t_mag != '0)
                && (t_mag < (T_W-1)'(max_dist_reg))
                && (!best_valid_reg || t_mag < (T_W-1)'(best_dist_reg));
        best_dist_nx  = take ? t_mag[DIST_W-1:0] : best_dist_reg;
        best_idx_nx   = take ? cnt_reg : best_idx_reg;
        best_valid_nx = take || best_valid_reg;
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;

        if (cmd.load) begin
            ocx_reg    <= OC_W'(org_x) - OC_W'(cen_x);
            ocy_reg    <= OC_W'(org_y) - OC_W'(cen_y);
            ocz_reg    <= OC_W'(org_z) - OC_W'(cen_z);
            dx_reg     <= dir_x;
            dy_reg     <= dir_y;
            dz_reg     <= dir_z;
            rad_in_reg <= radius;
            last_reg   <= last;
            hacc_reg   <= '0;
            disc_reg   <= '0;
        end else begin
            case (acc_sel_reg)
                MS_HX, MS_HY, MS_HZ: hacc_reg <= hacc_reg + prod_reg[HACC_W-1:0];
                MS_OX, MS_OY, MS_OZ: disc_reg <= disc_reg - prod_ext;
                MS_RR:               disc_reg <= disc_reg + prod_ext;
                MS_HHH:              disc_reg <= disc_reg + (prod_ext <<< (2 * HALF_W));
                MS_HHL:              disc_reg <= disc_reg + (prod_ext <<< (HALF_W + 1));
                MS_HLL:              disc_reg <= disc_reg + prod_ext;
                default:             disc_reg <= disc_reg;
            endcase
        end

        if (cmd.h_latch) begin
            h_reg    <= h_val;
            hmag_reg <= h_val[H_W-1] ? HMAG_W'(-h_val) : h_val[HMAG_W-1:0];
        end

        if (cmd.sqrt_init) begin
            sh_reg   <= disc_reg;
            rem_reg  <= '0;
            root_reg <= '0;
            miss_reg <= disc_reg[DISC_W-1];
        end else if (cmd.sqrt_step) begin
            sh_reg <= sh_reg << 2;
            if (rem_sh >= trial) begin
                rem_reg  <= rem_sh - trial;
                root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
            end else begin
                rem_reg  <= rem_sh;
                root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
            end
        end

        if (cmd.decide) begin
            best_dist_reg <= best_dist_nx;
            best_idx_reg  <= best_idx_nx;
        end
        if (cmd.emit) begin
            hit_reg      <= best_valid_nx;
            dist_out_reg <= best_valid_nx ? best_dist_nx : '0;
            idx_out_reg  <= best_valid_nx ? best_idx_nx : '0;
        end

        if (!aresetn) begin
            max_dist_reg   <= MAX_DIST_RESET;
            acc_sel_reg    <= MS_NONE;
            best_valid_reg <= 1'b0;
            cnt_reg        <= '0;
        end else begin
            if (cfg_we) begin
                max_dist_reg <= cfg_data;
            end
            acc_sel_reg <= cmd.mul_sel;
            if (cmd.decide) begin
                if (cmd.emit) begin
                    best_valid_reg <= 1'b0;
                    cnt_reg        <= '0;
                end else begin
                    best_valid_reg <= best_valid_nx;
                    if (!last_reg && cnt_reg < IDX_W'(IDX_LIMIT)) begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
            end
        end
    end

endmodule
`default_nettype wire

// ----- hdl/ray_sphere_nearest_hit.sv -----
// Tests one ray against one sphere per transaction and keeps the nearest hit with
// 0 < t < max_distance; the transaction flagged last_sphere produces one result and
// starts a new ray. A sphere occupies the block from one acceptance to the next, so no
// new sphere is taken before it is done: acceptance, the single shared multiplier (dot
// products, squares and |h|^2), the digit-by-digit square root and the compare. The
// result and m_valid are registered when the compare of a last sphere fires. The compare
// of a last sphere waits, and the input with it, while the previous result is still
// unaccepted. max_distance may be written whenever no sphere is in flight.
`default_nettype none
module ray_sphere_nearest_hit (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [rsnh_pkg::DIST_W-1:0]         cfg_data,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic signed [rsnh_pkg::COORD_W-1:0] s_ray_origin_x,
    input  wire logic signed [rsnh_pkg::COORD_W-1:0] s_ray_origin_y,
    input  wire logic signed [rsnh_pkg::COORD_W-1:0] s_ray_origin_z,
    input  wire logic signed [rsnh_pkg::DIR_W-1:0]   s_ray_dir_x,
    input  wire logic signed [rsnh_pkg::DIR_W-1:0]   s_ray_dir_y,
    input  wire logic signed [rsnh_pkg::DIR_W-1:0]   s_ray_dir_z,
    input  wire logic signed [rsnh_pkg::COORD_W-1:0] s_sphere_center_x,
    input  wire logic signed [rsnh_pkg::COORD_W-1:0] s_sphere_center_y,
    input  wire logic signed [rsnh_pkg::COORD_W-1:0] s_sphere_center_z,
    input  wire logic [rsnh_pkg::DIST_W-1:0]         s_sphere_radius,
    input  wire logic                                s_last_sphere,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic                                     m_hit_found,
    output logic [rsnh_pkg::DIST_W-1:0]              m_nearest_distance,
    output logic [rsnh_pkg::IDX_W-1:0]               m_nearest_index
);
    import rsnh_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    assign cfg_ready = 1'b1;

    rsnh_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    rsnh_dp u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .stat             (stat),
        .cfg_we           (cfg_valid),
        .cfg_data         (cfg_data),
        .org_x            (s_ray_origin_x),
        .org_y            (s_ray_origin_y),
        .org_z            (s_ray_origin_z),
        .dir_x            (s_ray_dir_x),
        .dir_y            (s_ray_dir_y),
        .dir_z            (s_ray_dir_z),
        .cen_x            (s_sphere_center_x),
        .cen_y            (s_sphere_center_y),
        .cen_z            (s_sphere_center_z),
        .radius           (s_sphere_radius),
        .last             (s_last_sphere),
        .hit_found        (m_hit_found),
        .nearest_distance (m_nearest_distance),
        .nearest_index    (m_nearest_index)
    );

endmodule
`default_nettype wire

// ----- bench/nearest_hit_checker.sv -----
`timescale 1ns / 100ps
module nearest_hit_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [rsnh_pkg::DIST_W-1:0]         cfg_data,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  logic signed [rsnh_pkg::COORD_W-1:0] s_ray_origin_x,
    input  logic signed [rsnh_pkg::COORD_W-1:0] s_ray_origin_y,
    input  logic signed [rsnh_pkg::COORD_W-1:0] s_ray_origin_z,
    input  logic signed [rsnh_pkg::DIR_W-1:0]   s_ray_dir_x,
    input  logic signed [rsnh_pkg::DIR_W-1:0]   s_ray_dir_y,
    input  logic signed [rsnh_pkg::DIR_W-1:0]   s_ray_dir_z,
    input  logic signed [rsnh_pkg::COORD_W-1:0] s_sphere_center_x,
    input  logic signed [rsnh_pkg::COORD_W-1:0] s_sphere_center_y,
    input  logic signed [rsnh_pkg::COORD_W-1:0] s_sphere_center_z,
    input  logic [rsnh_pkg::DIST_W-1:0]         s_sphere_radius,
    input  logic                                s_last_sphere,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic                                m_hit_found,
    input  logic [rsnh_pkg::DIST_W-1:0]         m_nearest_distance,
    input  logic [rsnh_pkg::IDX_W-1:0]          m_nearest_index,
    output int                                  fail_count,
    output int                                  hits_pending
);
    import rsnh_pkg::*;

    typedef logic signed [127:0] wide_t;

    typedef struct packed {
        logic              hit;
        logic [DIST_W-1:0] near_dist;
        logic [IDX_W-1:0]  idx;
    } hit_report_t;

    hit_report_t       expected_hits[$];
    logic [DIST_W-1:0] far_limit;
    logic [31:0]       best_dist;
    logic [IDX_W-1:0]  best_idx;
    logic              best_found;
    logic [IDX_W-1:0]  sphere_pos;

    assign hits_pending = expected_hits.size();

    function automatic wide_t near_root_distance(
        input logic signed [COORD_W-1:0] ox, oy, oz, cx, cy, cz,
        input logic signed [DIR_W-1:0] dx, dy, dz,
        input logic [DIST_W-1:0] rad,
        output logic valid_root);
        wide_t ocx, ocy, ocz, hdot, h, disc;
        logic [127:0] root, cand, mag;
        ocx = wide_t'(ox) - wide_t'(cx);
        ocy = wide_t'(oy) - wide_t'(cy);
        ocz = wide_t'(oz) - wide_t'(cz);
        hdot = ocx * wide_t'(dx) + ocy * wide_t'(dy) + ocz * wide_t'(dz);
        h = hdot >>> DIR_FRAC;
        disc = h * h - (ocx * ocx + ocy * ocy + ocz * ocz)
               + wide_t'({97'b0, rad}) * wide_t'({97'b0, rad});
        valid_root = !disc[127];
        mag = disc;
        root = '0;
        for (int i = 62; i >= 0; i--) begin
            cand = root | (128'd1 << i);
            if (cand * cand <= mag)
                root = cand;
        end
        return -h - wide_t'(root);
    endfunction

    always @(posedge aclk) begin
        wide_t       t;
        logic        ok;
        hit_report_t got, want;
        if (!aresetn) begin
            far_limit  <= MAX_DIST_RESET;
            best_dist  = {1'b0, MAX_DIST_RESET};
            best_idx   = '0;
            best_found = 1'b0;
            sphere_pos = '0;
            fail_count <= 0;
            expected_hits.delete();
        end else begin
            if (cfg_valid && cfg_ready)
                far_limit <= cfg_data;
            if (s_valid && s_ready) begin
                t = near_root_distance(s_ray_origin_x, s_ray_origin_y, s_ray_origin_z,
                                       s_sphere_center_x, s_sphere_center_y,
                                       s_sphere_center_z, s_ray_dir_x, s_ray_dir_y,
                                       s_ray_dir_z, s_sphere_radius, ok);
                // ties keep the earlier sphere
                if (ok && t > 0 && t < wide_t'({97'b0, far_limit})
                        && (!best_found || t < wide_t'({96'b0, best_dist}))) begin
                    best_dist  = t[31:0];
                    best_idx   = sphere_pos;
                    best_found = 1'b1;
                end
                if (s_last_sphere) begin
                    want.hit       = best_found;
                    want.near_dist = best_found ? best_dist[DIST_W-1:0] : '0;
                    want.idx       = best_found ? best_idx : '0;
                    expected_hits.push_back(want);
                    best_dist  = {1'b0, far_limit};
                    best_idx   = '0;
                    best_found = 1'b0;
                    sphere_pos = '0;
                end else if (sphere_pos < IDX_W'(IDX_LIMIT)) begin
                    sphere_pos = sphere_pos + 1'b1;
                end
            end
            if (m_valid && m_ready) begin
                got = '{m_hit_found, m_nearest_distance, m_nearest_index};
                if (expected_hits.size() == 0) begin
                    $display("%0t: result with nothing expected: hit %0b dist %0d idx %0d",
                             $time, got.hit, got.near_dist, got.idx);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_hits.pop_front();
                    if (got.hit !== want.hit) begin
                        $display("%0t: hit_found expected %0b actual %0b",
                                 $time, want.hit, got.hit);
                        fail_count <= fail_count + 1;
                    end
                    if (got.near_dist !== want.near_dist) begin
                        $display("%0t: nearest_distance expected %0d actual %0d",
                                 $time, want.near_dist, got.near_dist);
                        fail_count <= fail_count + 1;
                    end
                    if (got.idx !== want.idx) begin
                        $display("%0t: nearest_index expected %0d actual %0d",
                                 $time, want.idx, got.idx);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

// ----- bench/tb_ray_sphere_nearest_hit.sv -----
`timescale 1ns / 100ps
module tb_ray_sphere_nearest_hit;
    import rsnh_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int SETTLE      = 200;
    localparam int UNIT        = 16384;
    localparam logic signed [DIR_W-1:0] DIR_ONE = 16'sd16384;

    typedef struct {
        logic signed [COORD_W-1:0] ox, oy, oz, cx, cy, cz;
        logic signed [DIR_W-1:0]   dx, dy, dz;
        logic [DIST_W-1:0]         rad;
        logic                      last;
    } sphere_job_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0, cfg_ready;
    logic [DIST_W-1:0] cfg_data = '0;
    logic s_valid = 1'b0, s_ready;
    logic signed [COORD_W-1:0] s_ray_origin_x = '0, s_ray_origin_y = '0, s_ray_origin_z = '0;
    logic signed [DIR_W-1:0] s_ray_dir_x = '0, s_ray_dir_y = '0, s_ray_dir_z = '0;
    logic signed [COORD_W-1:0] s_sphere_center_x = '0, s_sphere_center_y = '0;
    logic signed [COORD_W-1:0] s_sphere_center_z = '0;
    logic [DIST_W-1:0] s_sphere_radius = '0;
    logic s_last_sphere = 1'b0;
    logic m_valid, m_ready = 1'b0, m_hit_found;
    logic [DIST_W-1:0] m_nearest_distance;
    logic [IDX_W-1:0] m_nearest_index;

    int  fail_count, hits_pending;
    int  cycle_count = 0;
    bit  quiet = 0;
    bit  hold_request = 0;
    logic signed [COORD_W-1:0] ray_ox, ray_oy, ray_oz;
    logic signed [DIR_W-1:0]   ray_dx, ray_dy, ray_dz;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    ray_sphere_nearest_hit DUT (.*);
    nearest_hit_checker checker_i (.*);

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // receiver: random stall bursts, plus one long hold-off on request
    initial begin
        int n;
        @(posedge aresetn);
        forever begin
            if (hold_request) begin
                m_ready <= 1'b0;
                for (int i = 0; i < 600; i++) @(posedge aclk);
                hold_request = 0;
            end else if (!quiet && $urandom_range(0, 2) == 0) begin
                m_ready <= 1'b0;
                n = $urandom_range(1, 9);
                for (int i = 0; i < n; i++) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                n = $urandom_range(1, 9);
                for (int i = 0; i < n; i++) @(posedge aclk);
            end
        end
    end

    task automatic send_sphere(input sphere_job_t j);
        int n;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            n = $urandom_range(1, 9);
            for (int i = 0; i < n; i++) @(posedge aclk);
        end
        s_ray_origin_x <= j.ox; s_ray_origin_y <= j.oy; s_ray_origin_z <= j.oz;
        s_ray_dir_x <= j.dx; s_ray_dir_y <= j.dy; s_ray_dir_z <= j.dz;
        s_sphere_center_x <= j.cx; s_sphere_center_y <= j.cy; s_sphere_center_z <= j.cz;
        s_sphere_radius <= j.rad;
        s_last_sphere <= j.last;
        s_valid <= 1'b1;
        do @(negedge aclk); while (!s_ready);
        @(posedge aclk);
    endtask

    task automatic write_far_limit(input logic [DIST_W-1:0] value);
        s_valid <= 1'b0;
        wait (hits_pending == 0);
        for (int i = 0; i < 100; i++) @(posedge aclk);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(negedge aclk); while (!cfg_ready);
        @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic pick_ray();
        ray_ox = $signed($urandom_range(0, 1 << 25)) - (1 << 24);
        ray_oy = $signed($urandom_range(0, 1 << 25)) - (1 << 24);
        ray_oz = $signed($urandom_range(0, 1 << 25)) - (1 << 24);
        case ($urandom_range(0, 3))
            0: begin
                ray_dx = '0; ray_dy = '0; ray_dz = '0;
                case ($urandom_range(0, 2))
                    0: ray_dx = $urandom_range(0, 1) ? DIR_ONE : -DIR_ONE;
                    1: ray_dy = $urandom_range(0, 1) ? DIR_ONE : -DIR_ONE;
                    default: ray_dz = $urandom_range(0, 1) ? DIR_ONE : -DIR_ONE;
                endcase
            end
            1: begin
                ray_dx = $urandom_range(0, 1) ? 16'sd9459 : -16'sd9459;
                ray_dy = $urandom_range(0, 1) ? 16'sd9459 : -16'sd9459;
                ray_dz = $urandom_range(0, 1) ? 16'sd9459 : -16'sd9459;
            end
            2: begin
                ray_dx = $urandom_range(0, 1) ? 16'sd11585 : -16'sd11585;
                ray_dy = $urandom_range(0, 1) ? 16'sd11585 : -16'sd11585;
                ray_dz = '0;
            end
            default: begin
                // off-unit direction, used as given
                ray_dx = DIR_W'($signed($urandom_range(0, 2 * UNIT)) - UNIT);
                ray_dy = DIR_W'($signed($urandom_range(0, 2 * UNIT)) - UNIT);
                ray_dz = DIR_W'($signed($urandom_range(0, 2 * UNIT)) - UNIT);
            end
        endcase
    endtask

    function automatic sphere_job_t ahead_sphere(input bit last);
        sphere_job_t j;
        longint span;
        span = $urandom_range(1, 1 << 22);
        j = '{ray_ox, ray_oy, ray_oz, ray_ox, ray_oy, ray_oz,
              ray_dx, ray_dy, ray_dz, '0, last};
        j.cx = COORD_W'(ray_ox + ((longint'(ray_dx) * span) >>> 14)
                        + $signed($urandom_range(0, 64)) - 32);
        j.cy = COORD_W'(ray_oy + ((longint'(ray_dy) * span) >>> 14)
                        + $signed($urandom_range(0, 64)) - 32);
        j.cz = COORD_W'(ray_oz + ((longint'(ray_dz) * span) >>> 14)
                        + $signed($urandom_range(0, 64)) - 32);
        case ($urandom_range(0, 5))
            0: j.rad = DIST_W'($urandom_range(0, 1 << 23));
            1: j.rad = DIST_W'($urandom_range(0, 8));
            default: j.rad = DIST_W'($urandom_range(0, span));
        endcase
        return j;
    endfunction

    function automatic sphere_job_t noise_sphere(input bit last);
        sphere_job_t j;
        j.ox = $urandom; j.oy = $urandom; j.oz = $urandom;
        j.cx = $urandom; j.cy = $urandom; j.cz = $urandom;
        j.dx = DIR_W'($signed($urandom_range(0, 2 * UNIT)) - UNIT);
        j.dy = DIR_W'($signed($urandom_range(0, 2 * UNIT)) - UNIT);
        j.dz = DIR_W'($signed($urandom_range(0, 2 * UNIT)) - UNIT);
        j.rad = DIST_W'($urandom);
        j.last = last;
        return j;
    endfunction

    task automatic send_ray(input int count);
        pick_ray();
        for (int k = 0; k < count; k++)
            send_sphere($urandom_range(0, 9) == 0 ? noise_sphere(k == count - 1)
                                                : ahead_sphere(k == count - 1));
    endtask

    initial begin
        sphere_job_t j;
        int sent;
        for (int i = 0; i < 12; i++) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // sphere straight ahead on +x, 10 units away, radius 2
        j = '{0, 0, 0, 10 <<< 12, 0, 0, DIR_ONE, '0, '0, DIST_W'(2 << 12), 1'b1};
        send_sphere(j);
        // miss: sphere off to the side
        j.cy = 50 <<< 12; send_sphere(j);
        // sphere behind the origin
        j.cy = 0; j.cx = -(10 <<< 12); send_sphere(j);
        // origin inside the sphere
        j.cx = 1 <<< 12; j.rad = DIST_W'(5 << 12); send_sphere(j);
        // two identical spheres: the first keeps the tie, then a nearer one
        j = '{0, 0, 0, 0, -(20 <<< 12), 0, '0, -DIR_ONE, '0, DIST_W'(3 << 12), 1'b0};
        send_sphere(j); send_sphere(j);
        j.cy = -(8 <<< 12); send_sphere(j);
        j.cy = -(30 <<< 12); j.last = 1'b1; send_sphere(j);
        // extreme coordinates, direction and radius
        j = '{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
              32'sh80000000, -DIR_ONE, DIR_ONE, -DIR_ONE, 31'h7fffffff, 1'b1};
        send_sphere(j);
        j = '{32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff,
              32'sh7fffffff, DIR_ONE, DIR_ONE, DIR_ONE, 31'h0, 1'b1};
        send_sphere(j);
        // zero direction, zero radius at the origin
        j = '{0, 0, 0, 0, 0, 0, '0, '0, '0, '0, 1'b1};
        send_sphere(j);
        j.rad = DIST_W'(1 << 12); send_sphere(j);
        // hit beyond the reset far limit
        j = '{0, 0, 0, 0, 0, 20000 <<< 12, '0, '0, DIR_ONE, DIST_W'(1 << 12), 1'b1};
        send_sphere(j);

        write_far_limit(31'd0);
        j = '{0, 0, 0, 10 <<< 12, 0, 0, DIR_ONE, '0, '0, DIST_W'(2 << 12), 1'b1};
        send_sphere(j);
        write_far_limit(31'h7fffffff);
        j = '{0, 0, 0, 0, 0, 20000 <<< 12, '0, '0, DIR_ONE, DIST_W'(1 << 12), 1'b1};
        send_sphere(j);
        write_far_limit(31'd1);
        send_ray(3);
        write_far_limit(DIST_W'(8 << 12));
        j = '{0, 0, 0, 8 <<< 12, 0, 0, DIR_ONE, '0, '0, '0, 1'b1};
        send_sphere(j);
        j.cx = (8 <<< 12) + 1; j.rad = 31'd1; send_sphere(j);
        write_far_limit(MAX_DIST_RESET);

        // saturating sphere position
        send_ray(70);

        // long receiver hold-off while single-sphere rays keep coming
        hold_request = 1;
        for (int k = 0; k < 12; k++) send_ray(1);

        sent = 0;
        while (sent < 620) begin
            int n;
            if (sent % 150 == 149 || (sent > 0 && $urandom_range(0, 40) == 0))
                write_far_limit($urandom_range(0, 1)
                                ? DIST_W'($urandom_range(1 << 12, 1 << 24))
                                : DIST_W'($urandom));
            if (sent > 520) quiet = 1;
            n = $urandom_range(0, 15) == 0 ? $urandom_range(7, 20) : $urandom_range(1, 5);
            send_ray(n);
            sent += n;
        end
        s_valid <= 1'b0;

        wait (hits_pending == 0);
        for (int i = 0; i < SETTLE; i++) @(posedge aclk);
        if (fail_count == 0 && hits_pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
